// File: rtl/tvls_pkg.sv
// ----------------------------------------------------------------------------
// tvls_pkg
// Shared widths, register indexes, request codes and reset values of the
// text video line sequencer.
// ----------------------------------------------------------------------------
package tvls_pkg;

	localparam int LINE_W     = 10;
	localparam int ADDR_W     = 16;
	localparam int COLOR_W    = 8;
	localparam int ROW_IDX_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CELL_W     = 8;
	localparam int VREQ_W     = 2;
	localparam int FRAME_W    = 2;

	localparam int DEF_ROWS       = 16;
	localparam int DEF_ROW_STRIDE = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VSYNC_START = 3'd0,
		CFG_VSYNC_END   = 3'd1,
		CFG_FRAME_TOP   = 3'd2,
		CFG_FRAME_END   = 3'd3,
		CFG_TEXT_END    = 3'd4,
		CFG_LAST_LINE   = 3'd5,
		CFG_VRAM_LINE   = 3'd6,
		CFG_BASE_ADDR   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		REQ_LINE_TICK   = 1'b0,
		REQ_TABLE_WRITE = 1'b1
	} req_type_t;

	typedef enum logic [VREQ_W-1:0] {
		VREQ_NONE = 2'd0,
		VREQ_EVEN = 2'd1,
		VREQ_ODD  = 2'd2
	} vreq_t;

	localparam logic [3:0] CELL_MASK       = 4'hF;
	localparam logic [3:0] CELL_ADDR_LINES = 4'd7;
	localparam logic [3:0] CELL_COLOR_LINE = 4'd9;

	localparam logic [LINE_W-1:0] RST_VSYNC_START = 10'd248;
	localparam logic [LINE_W-1:0] RST_VSYNC_END   = 10'd251;
	localparam logic [LINE_W-1:0] RST_FRAME_TOP   = 10'd30;
	localparam logic [LINE_W-1:0] RST_FRAME_END   = 10'd240;
	localparam logic [LINE_W-1:0] RST_TEXT_END    = 10'd222;
	localparam logic [LINE_W-1:0] RST_LAST_LINE   = 10'd262;
	localparam logic [LINE_W-1:0] RST_VRAM_LINE   = 10'd245;
	localparam logic [ADDR_W-1:0] RST_BASE_ADDR   = 16'd0;

endpackage

// File: rtl/tvls_ram.sv
// ----------------------------------------------------------------------------
// tvls_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tvls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tvls_color_table.sv
// ----------------------------------------------------------------------------
// tvls_color_table
// Even and odd field row colour tables in one RAM, with per-entry valid bits
// so that entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module tvls_color_table #(
	parameter int ROWS = 16,
	localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int AW  = RW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [tvls_pkg::COLOR_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [tvls_pkg::COLOR_W-1:0] rdata
);

	import tvls_pkg::*;

	localparam int DEPTH = 2 ** AW;

	logic [DEPTH-1:0]   valid_q;
	logic               rd_valid_q;
	logic [COLOR_W-1:0] ram_rdata;

	tvls_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? ram_rdata : '0;

endmodule

// File: rtl/text_video_line_sequencer.sv
// ----------------------------------------------------------------------------
// text_video_line_sequencer
// Vertical timing of a text-mode video controller: per line tick it reports
// the line state, then steps line, cell line, address, row colour, field and
// the video memory update request. Row colours live in a RAM.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    req_type table_select row_index
//                                   color_value vram_ack
//   out      out_valid / out_ready  line_addr pixel_on line_color odd_field
//                                   wide_sync vram_request slow_tick
//   cfg      cfg_wr_en              cfg_index cfg_data
//
// One transaction per cycle while in_ready is high; results are registered.
// A colour load reads the RAM; the read data is forwarded to a transaction
// taken in the cycle after the load and then held in the colour register.
// in_ready is low only while a result is held and out_ready is low.
// Reset clears all counters, flags and table valid bits at once.
// ----------------------------------------------------------------------------
module text_video_line_sequencer #(
	parameter int ROWS       = tvls_pkg::DEF_ROWS,
	parameter int ROW_STRIDE = tvls_pkg::DEF_ROW_STRIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic                            table_select,
	input  logic [tvls_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [tvls_pkg::COLOR_W-1:0]    color_value,
	input  logic                            vram_ack,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tvls_pkg::ADDR_W-1:0]     line_addr,
	output logic                            pixel_on,
	output logic [tvls_pkg::COLOR_W-1:0]    line_color,
	output logic                            odd_field,
	output logic                            wide_sync,
	output logic [tvls_pkg::VREQ_W-1:0]     vram_request,
	output logic                            slow_tick,
	input  logic                            cfg_wr_en,
	input  logic [tvls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvls_pkg::CFG_DATA_W-1:0] cfg_data
);

	import tvls_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW = RW + 1;

	// configuration
	logic [LINE_W-1:0] vsync_start_q, vsync_end_q, frame_top_q, frame_end_q;
	logic [LINE_W-1:0] text_end_q, last_line_q, vram_line_q;
	logic [ADDR_W-1:0] base_addr_q;

	// line state
	logic [LINE_W-1:0]  line_count_q, line_count_d;
	logic [CELL_W-1:0]  cell_q, cell_d;
	logic [ADDR_W-1:0]  data_addr_q, data_addr_d;
	logic [RW-1:0]      row_q, row_d;
	logic [COLOR_W-1:0] color_q, color_eff;
	logic               pix_q, pix_d;
	logic               parity_q, parity_d;
	logic               wide_q, wide_d;
	logic [VREQ_W-1:0]  pend_q, pend_d, pend_eff;
	logic [FRAME_W-1:0] frame_q, frame_d;
	logic               slow_d;
	logic               load_d, load_s1;

	// output register
	logic               out_valid_q;
	logic [ADDR_W-1:0]  o_addr_q;
	logic               o_pix_q, o_odd_q, o_wide_q, o_slow_q;
	logic [COLOR_W-1:0] o_color_q;
	logic [VREQ_W-1:0]  o_vreq_q;

	// colour table
	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr, tbl_raddr;
	logic [COLOR_W-1:0] tbl_rdata;

	logic               in_acc;
	logic [LINE_W-1:0]  line;
	logic [3:0]         cl;
	logic [RW:0]        row_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign color_eff = load_s1 ? tbl_rdata : color_q;
	assign pend_eff  = vram_ack ? VREQ_NONE : pend_q;
	assign line      = line_count_q + 1'b1;
	assign cl        = cell_q[3:0] & CELL_MASK;
	assign row_inc   = {1'b0, row_q} + 1'b1;

	assign tbl_we    = in_acc && (req_type == REQ_TABLE_WRITE) && (32'(row_index) < ROWS);
	assign tbl_waddr = {table_select, RW'(row_index)};
	assign tbl_raddr = {parity_q, row_q};

	always_comb begin
		line_count_d = line_count_q;
		cell_d       = cell_q;
		data_addr_d  = data_addr_q;
		row_d        = row_q;
		pix_d        = pix_q;
		parity_d     = parity_q;
		wide_d       = wide_q;
		frame_d      = frame_q;
		pend_d       = pend_eff;
		slow_d       = 1'b0;
		load_d       = 1'b0;
		if (req_type == REQ_LINE_TICK) begin
			line_count_d = line;
			if (line == vsync_end_q) begin
				wide_d = 1'b0;
				pix_d  = 1'b0;
			end else if (line >= frame_top_q && line < frame_end_q) begin
				pix_d = 1'b0;
				if (line < text_end_q) begin
					if (cl < CELL_ADDR_LINES) begin
						data_addr_d = data_addr_q + ADDR_W'(ROW_STRIDE);
						pix_d       = 1'b1;
					end else if (cl == CELL_COLOR_LINE) begin
						load_d = 1'b1;
						row_d  = (row_inc >= (RW+1)'(ROWS)) ? '0 : row_inc[RW-1:0];
					end
					cell_d = cell_q + 1'b1;
				end
			end else if (line == last_line_q) begin
				pix_d        = 1'b0;
				line_count_d = '0;
				cell_d       = '0;
				frame_d      = frame_q + 1'b1;
				slow_d       = (frame_d == '0);
				parity_d     = !parity_q;
			end else if (line == vsync_start_q) begin
				wide_d      = 1'b1;
				pix_d       = 1'b0;
				data_addr_d = base_addr_q;
				row_d       = '0;
			end
			if (line_count_d == vram_line_q && pend_eff == VREQ_NONE) begin
				pend_d = parity_q ? VREQ_ODD : VREQ_EVEN;
			end
		end
	end

	tvls_color_table #(
		.ROWS(ROWS)
	) u_color_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (color_value),
		.re     (in_acc && load_d),
		.raddr  (tbl_raddr),
		.rdata  (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsync_start_q <= RST_VSYNC_START;
			vsync_end_q   <= RST_VSYNC_END;
			frame_top_q   <= RST_FRAME_TOP;
			frame_end_q   <= RST_FRAME_END;
			text_end_q    <= RST_TEXT_END;
			last_line_q   <= RST_LAST_LINE;
			vram_line_q   <= RST_VRAM_LINE;
			base_addr_q   <= RST_BASE_ADDR;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_VSYNC_START: vsync_start_q <= cfg_data[LINE_W-1:0];
				CFG_VSYNC_END:   vsync_end_q   <= cfg_data[LINE_W-1:0];
				CFG_FRAME_TOP:   frame_top_q   <= cfg_data[LINE_W-1:0];
				CFG_FRAME_END:   frame_end_q   <= cfg_data[LINE_W-1:0];
				CFG_TEXT_END:    text_end_q    <= cfg_data[LINE_W-1:0];
				CFG_LAST_LINE:   last_line_q   <= cfg_data[LINE_W-1:0];
				CFG_VRAM_LINE:   vram_line_q   <= cfg_data[LINE_W-1:0];
				CFG_BASE_ADDR:   base_addr_q   <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			cell_q       <= '0;
			data_addr_q  <= '0;
			row_q        <= '0;
			color_q      <= '0;
			pix_q        <= 1'b0;
			parity_q     <= 1'b0;
			wide_q       <= 1'b0;
			pend_q       <= VREQ_NONE;
			frame_q      <= '0;
			load_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			color_q <= color_eff;
			load_s1 <= in_acc && load_d;
			if (in_acc) begin
				line_count_q <= line_count_d;
				cell_q       <= cell_d;
				data_addr_q  <= data_addr_d;
				row_q        <= row_d;
				pix_q        <= pix_d;
				parity_q     <= parity_d;
				wide_q       <= wide_d;
				pend_q       <= pend_d;
				frame_q      <= frame_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			o_addr_q  <= data_addr_q;
			o_pix_q   <= pix_q;
			o_color_q <= color_eff;
			o_odd_q   <= parity_q;
			o_wide_q  <= wide_q;
			o_vreq_q  <= pend_d;
			o_slow_q  <= slow_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_addr    = o_addr_q;
	assign pixel_on     = o_pix_q;
	assign line_color   = o_color_q;
	assign odd_field    = o_odd_q;
	assign wide_sync    = o_wide_q;
	assign vram_request = o_vreq_q;
	assign slow_tick    = o_slow_q;

endmodule
